@@ src/kci_pkg.sv @@
// Shared types, widths and codes of the keyframe camera interpolator.
// No dependencies; every other file of the block imports this package.
package kci_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int IDX_W     = $clog2(MAX_KEYS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int NCOORD    = 6;
  localparam int CW        = 32;
  localparam int TW        = 32;
  localparam int POS_W     = 6;
  localparam int IT_W      = $clog2(FRAC_BITS + 1);
  localparam int PROD_W    = CW + 1 + FRAC_BITS + 1;

  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef enum logic [1:0] {
    K_QUERY,
    K_INSERT,
    K_DELETE,
    K_PASS
  } kind_e;

  typedef logic [NCOORD-1:0][CW-1:0] cam_t;

  typedef struct packed {
    kind_e             kind;
    logic [TW-1:0]     tval;
    cam_t              cam;
    logic              glide;
    logic [POS_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic [TW-1:0] tkey;
    cam_t          cam;
    logic          glide;
  } row_t;

  typedef struct packed {
    cam_t              cam;
    logic              changed;
    logic [POS_W-1:0]  position;
    logic [1:0]        status;
  } res_t;

endpackage

@@ src/kci_front.sv @@
// Front end: a two-entry command queue that accepts and classifies operations.
// Depends on kci_pkg.
module kci_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_vld_i,
  output logic                  in_full_o,
  input  logic [1:0]            op_i,
  input  logic [kci_pkg::TW-1:0] time_value_i,
  input  kci_pkg::cam_t         cam_i,
  input  logic                  glide_in_i,
  input  logic [kci_pkg::POS_W-1:0] key_index_i,
  output logic                  cmd_vld_o,
  input  logic                  cmd_rdy_i,
  output kci_pkg::cmd_t         cmd_o
);
  import kci_pkg::*;

  cmd_t       q_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_d;
  logic       push_ok, pop_ok;

  always_comb begin
    cmd_d.tval  = time_value_i;
    cmd_d.cam   = cam_i;
    cmd_d.glide = glide_in_i;
    cmd_d.idx   = key_index_i;
    case (op_i)
      OP_QUERY:  cmd_d.kind = K_QUERY;
      OP_INSERT: cmd_d.kind = K_INSERT;
      OP_DELETE: cmd_d.kind = K_DELETE;
      default:   cmd_d.kind = K_PASS;
    endcase
  end

  assign in_full_o = (cnt_q == 2'd2);
  assign cmd_vld_o = (cnt_q != 2'd0);
  assign cmd_o     = q_q[rp_q];
  assign push_ok   = in_vld_i && !in_full_o;
  assign pop_ok    = cmd_vld_o && cmd_rdy_i;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_q[wp_q] <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_q <= ~wp_q;
      end
      if (pop_ok) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

@@ src/kci_engine.sv @@
// Back end: keyframe table memory, segment scan, table shifting, serial divider
// and shared blend multiplier. Depends on kci_pkg.
module kci_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          hold_i,
  input  logic          cmd_vld_i,
  output logic          cmd_rdy_o,
  input  kci_pkg::cmd_t cmd_i,
  output logic          res_vld_o,
  input  logic          res_rdy_i,
  output kci_pkg::res_t res_o
);
  import kci_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_RDPREV   = 4'd2;
  localparam logic [3:0] S_WAITPREV = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_MUL      = 4'd5;
  localparam logic [3:0] S_ADD      = 4'd6;
  localparam logic [3:0] S_FIN      = 4'd7;
  localparam logic [3:0] S_SHRD     = 4'd8;
  localparam logic [3:0] S_SHWR     = 4'd9;
  localparam logic [3:0] S_INSWR    = 4'd10;
  localparam logic [3:0] S_DLRD     = 4'd11;
  localparam logic [3:0] S_DLWR     = 4'd12;
  localparam logic [3:0] S_DLEND    = 4'd13;
  localparam logic [3:0] S_DLWAIT   = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  row_t                    mem_q [MAX_KEYS];
  row_t                    rd_q, cur_q, nxt_q, mem_wd;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa, mem_ra;

  logic [3:0]              state_q;
  cmd_t                    cmd_q;
  logic [CNT_W-1:0]        count_q, scan_q, cmp_q, j_q;
  logic                    cmp_vld_q, interp_q, blend_q;
  logic [IDX_W-1:0]        fi_q;
  cam_t                    cam_q, new_cam_q;
  logic                    changed_q;
  logic [POS_W-1:0]        pos_q;
  logic [1:0]              status_q;
  logic [TW-1:0]           rem_q, dvs_q;
  logic [FRAC_BITS-1:0]    quo_q;
  logic [IT_W-1:0]         it_q;
  logic [2:0]              k_q;
  logic signed [PROD_W-1:0] prod_q;

  logic                    hit, last, ge;
  logic [TW:0]             r2;
  logic signed [CW:0]      diff;
  logic [CW-1:0]           ca, cb;
  logic [IDX_W-1:0]        prev_idx;
  row_t                    ins_row;

  assign hit  = cmd_q.tval < rd_q.tkey;
  assign last = (cmp_q == count_q - CNT_W'(1));
  assign r2   = {rem_q, 1'b0};
  assign ge   = r2 >= {1'b0, dvs_q};
  assign ca   = cur_q.cam[k_q];
  assign cb   = nxt_q.cam[k_q];
  assign diff = $signed({cb[CW-1], cb}) - $signed({ca[CW-1], ca});
  assign prev_idx = (cmd_q.idx != '0) ? IDX_W'(cmd_q.idx - POS_W'(1)) : '0;

  always_comb begin
    ins_row.tkey  = cmd_q.tval;
    ins_row.cam   = cmd_q.cam;
    ins_row.glide = (pos_q == '0) ? 1'b0 : cmd_q.glide;
  end

  always_comb begin
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_q;
    case (state_q)
      S_SCAN:   mem_ra = scan_q[IDX_W-1:0];
      S_RDPREV: mem_ra = fi_q;
      S_SHRD:   mem_ra = IDX_W'(j_q - CNT_W'(1));
      S_SHWR: begin
        mem_we = 1'b1;
        mem_wa = j_q[IDX_W-1:0];
      end
      S_INSWR: begin
        mem_we = 1'b1;
        mem_wa = pos_q[IDX_W-1:0];
        mem_wd = ins_row;
      end
      S_DLRD:   mem_ra = IDX_W'(j_q + CNT_W'(1));
      S_DLWR: begin
        mem_we = 1'b1;
        mem_wa = j_q[IDX_W-1:0];
      end
      S_DLEND:  mem_ra = prev_idx;
      default:  mem_ra = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  assign cmd_rdy_o = (state_q == S_IDLE);
  assign res_vld_o = (state_q == S_DONE);
  assign res_o.cam      = cam_q;
  assign res_o.changed  = changed_q;
  assign res_o.position = pos_q;
  assign res_o.status   = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      interp_q  <= 1'b0;
      cam_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmd_q     <= '0;
      scan_q    <= '0;
      cmp_q     <= '0;
      j_q       <= '0;
      blend_q   <= 1'b0;
      fi_q      <= '0;
      new_cam_q <= '0;
      changed_q <= 1'b0;
      pos_q     <= '0;
      status_q  <= ST_OK;
      rem_q     <= '0;
      dvs_q     <= '0;
      quo_q     <= '0;
      it_q      <= '0;
      k_q       <= '0;
      prod_q    <= '0;
      cur_q     <= '0;
      nxt_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_vld_i) begin
            cmd_q     <= cmd_i;
            changed_q <= 1'b0;
            status_q  <= ST_OK;
            pos_q     <= '0;
            cmp_vld_q <= 1'b0;
            case (cmd_i.kind)
              K_QUERY: begin
                if (hold_i || !interp_q || count_q < CNT_W'(2)) begin
                  state_q <= S_DONE;
                end else begin
                  scan_q  <= CNT_W'(1);
                  state_q <= S_SCAN;
                end
              end
              K_INSERT: begin
                if (count_q == CNT_W'(MAX_KEYS)) begin
                  status_q <= ST_FULL;
                  state_q  <= S_DONE;
                end else if (count_q == '0) begin
                  state_q <= S_INSWR;
                end else begin
                  scan_q  <= '0;
                  state_q <= S_SCAN;
                end
              end
              K_DELETE: begin
                if (count_q <= CNT_W'(1) || CNT_W'(cmd_i.idx) >= count_q) begin
                  status_q <= ST_REFUSED;
                  state_q  <= S_DONE;
                end else begin
                  j_q <= CNT_W'(cmd_i.idx);
                  if (CNT_W'(cmd_i.idx) + CNT_W'(1) < count_q) begin
                    state_q <= S_DLRD;
                  end else begin
                    state_q <= S_DLEND;
                  end
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          scan_q    <= scan_q + CNT_W'(1);
          cmp_q     <= scan_q;
          cmp_vld_q <= 1'b1;
          if (cmp_vld_q && (hit || last)) begin
            cmp_vld_q <= 1'b0;
            if (cmd_q.kind == K_QUERY) begin
              nxt_q <= rd_q;
              if (hit) begin
                fi_q    <= IDX_W'(cmp_q - CNT_W'(1));
                pos_q   <= POS_W'(cmp_q - CNT_W'(1));
                blend_q <= rd_q.glide;
              end else begin
                fi_q    <= cmp_q[IDX_W-1:0];
                pos_q   <= POS_W'(cmp_q);
                blend_q <= 1'b0;
              end
              state_q <= S_RDPREV;
            end else begin
              j_q <= count_q;
              if (hit) begin
                pos_q <= POS_W'(cmp_q);
                state_q <= (count_q > cmp_q) ? S_SHRD : S_INSWR;
              end else begin
                pos_q   <= POS_W'(count_q);
                state_q <= S_INSWR;
              end
            end
          end
        end
        S_RDPREV: state_q <= S_WAITPREV;
        S_WAITPREV: begin
          cur_q <= rd_q;
          if (!blend_q) begin
            new_cam_q <= rd_q.cam;
            state_q   <= S_FIN;
          end else if (cmd_q.tval >= rd_q.tkey && nxt_q.tkey > rd_q.tkey) begin
            rem_q   <= cmd_q.tval - rd_q.tkey;
            dvs_q   <= nxt_q.tkey - rd_q.tkey;
            quo_q   <= '0;
            it_q    <= '0;
            state_q <= S_DIV;
          end else begin
            quo_q   <= '0;
            k_q     <= '0;
            state_q <= S_MUL;
          end
        end
        S_DIV: begin
          rem_q <= ge ? TW'(r2 - {1'b0, dvs_q}) : r2[TW-1:0];
          quo_q <= {quo_q[FRAC_BITS-2:0], ge};
          it_q  <= it_q + IT_W'(1);
          if (it_q == IT_W'(FRAC_BITS - 1)) begin
            k_q     <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= PROD_W'(diff * $signed({1'b0, quo_q}));
          state_q <= S_ADD;
        end
        S_ADD: begin
          new_cam_q[k_q] <= ca + prod_q[FRAC_BITS +: CW];
          if (k_q == 3'(NCOORD - 1)) begin
            state_q <= S_FIN;
          end else begin
            k_q     <= k_q + 3'd1;
            state_q <= S_MUL;
          end
        end
        S_FIN: begin
          changed_q <= (new_cam_q != cam_q);
          cam_q     <= new_cam_q;
          state_q   <= S_DONE;
        end
        S_SHRD: state_q <= S_SHWR;
        S_SHWR: begin
          j_q <= j_q - CNT_W'(1);
          state_q <= (j_q - CNT_W'(1) > CNT_W'(pos_q)) ? S_SHRD : S_INSWR;
        end
        S_INSWR: begin
          count_q <= count_q + CNT_W'(1);
          if (count_q != '0) begin
            interp_q <= 1'b1;
          end
          state_q <= S_DONE;
        end
        S_DLRD: state_q <= S_DLWR;
        S_DLWR: begin
          j_q <= j_q + CNT_W'(1);
          state_q <= (j_q + CNT_W'(2) < count_q) ? S_DLRD : S_DLEND;
        end
        S_DLEND: begin
          count_q <= count_q - CNT_W'(1);
          pos_q   <= cmd_q.idx;
          state_q <= S_DLWAIT;
        end
        S_DLWAIT: begin
          new_cam_q <= rd_q.cam;
          state_q   <= S_FIN;
        end
        S_DONE: begin
          if (res_rdy_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/keyframe_camera_interpolator.sv @@
// Top level of the keyframe camera interpolator: command queue, engine and
// a two-entry result queue, plus the hold_output register. Depends on kci_pkg.
//
// Usage: operations (query, insert, delete) enter through push/full and each
// yields exactly one result transaction on empty/pop, in order. The hold_output
// register is to be written with cfg_we_i/cfg_data_i only while the block is
// idle; the block itself does not enforce this. Work per operation:
//   query with hold, fewer than two keys, refused op or op 3: straight to result;
//   query: a scan of the keys up to the segment, a read of its first key, then
//   the serial divider and a blend of each coordinate when the segment glides;
//   insert: a scan for slot p, a move of each key from p up, then the write;
//   delete: a move of each later key down, then a read of the key before it.
// One operation is worked at a time; the command queue takes up to two more.
// Reset empties both queues, clears the key count, the camera and the hold
// register. The table needs no clearing. When the receiver stalls, results
// collect in the result queue; once it is full the engine waits, then the
// command queue fills and full rises.
module keyframe_camera_interpolator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                op_i,
  input  logic [31:0]               time_value_i,
  input  logic signed [31:0]        target_x_i,
  input  logic signed [31:0]        target_y_i,
  input  logic signed [31:0]        target_z_i,
  input  logic signed [31:0]        eye_x_i,
  input  logic signed [31:0]        eye_y_i,
  input  logic signed [31:0]        eye_z_i,
  input  logic                      glide_in_i,
  input  logic [5:0]                key_index_i,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [31:0]        out_target_x_o,
  output logic signed [31:0]        out_target_y_o,
  output logic signed [31:0]        out_target_z_o,
  output logic signed [31:0]        out_eye_x_o,
  output logic signed [31:0]        out_eye_y_o,
  output logic signed [31:0]        out_eye_z_o,
  output logic                      changed_o,
  output logic [5:0]                position_o,
  output logic [1:0]                status_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_data_i
);
  import kci_pkg::*;

  logic       hold_q;
  cam_t       in_cam;
  cmd_t       cmd;
  logic       cmd_vld, cmd_rdy;
  res_t       res;
  logic       res_vld;
  res_t       oq_q [2];
  logic       owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic       oq_full, oq_push, oq_pop;
  res_t       head;

  assign in_cam = {eye_z_i, eye_y_i, eye_x_i, target_z_i, target_y_i, target_x_i};

  kci_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (push),
    .in_full_o    (full),
    .op_i         (op_i),
    .time_value_i (time_value_i),
    .cam_i        (in_cam),
    .glide_in_i   (glide_in_i),
    .key_index_i  (key_index_i),
    .cmd_vld_o    (cmd_vld),
    .cmd_rdy_i    (cmd_rdy),
    .cmd_o        (cmd)
  );

  kci_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hold_i    (hold_q),
    .cmd_vld_i (cmd_vld),
    .cmd_rdy_o (cmd_rdy),
    .cmd_i     (cmd),
    .res_vld_o (res_vld),
    .res_rdy_i (!oq_full),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else if (cfg_we_i) begin
      hold_q <= cfg_data_i;
    end
  end

  assign oq_full = (ocnt_q == 2'd2);
  assign empty   = (ocnt_q == 2'd0);
  assign oq_push = res_vld && !oq_full;
  assign oq_pop  = pop && !empty;
  assign head    = oq_q[orp_q];

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[owp_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (oq_push) begin
        owp_q <= ~owp_q;
      end
      if (oq_pop) begin
        orp_q <= ~orp_q;
      end
      ocnt_q <= ocnt_q + {1'b0, oq_push} - {1'b0, oq_pop};
    end
  end

  assign out_target_x_o = head.cam[0];
  assign out_target_y_o = head.cam[1];
  assign out_target_z_o = head.cam[2];
  assign out_eye_x_o    = head.cam[3];
  assign out_eye_y_o    = head.cam[4];
  assign out_eye_z_o    = head.cam[5];
  assign changed_o      = head.changed;
  assign position_o     = head.position;
  assign status_o       = head.status;

`ifndef ASSERT_OFF
  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q != 2'd3) else $error("result queue overflow");

  a_full_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_FULL) |-> (position_o == '0 && !changed_o))
    else $error("table-full result carries a position or a change");

  a_refused_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_REFUSED) |-> (position_o == '0 && !changed_o))
    else $error("refused delete carries a position or a change");
`endif

endmodule
